/* rtl/core/integer_merge_sorter_assert.svh */
// ----------------------------------------------------------------------------
// integer_merge_sorter assertion macros
// Shared property forms for the merge sorter checks.
// ----------------------------------------------------------------------------
`ifndef INTEGER_MERGE_SORTER_ASSERT_SVH
`define INTEGER_MERGE_SORTER_ASSERT_SVH

// same-cycle implication
`define IMS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("integer_merge_sorter: same-cycle check failed");

// next-cycle implication
`define IMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("integer_merge_sorter: next-cycle check failed");

`endif

/* rtl/core/ims_pkg.sv */
// ----------------------------------------------------------------------------
// ims_pkg
// Shared widths, defaults and the queue entry type of the merge sorter.
// ----------------------------------------------------------------------------
package ims_pkg;

    localparam int DATA_W           = 32;
    localparam int MAX_ELEMENTS_DEF = 64;
    localparam int QUEUE_DEPTH      = 4;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              keep;
        logic              last;
        logic              drop;
    } t_entry;

endpackage

/* rtl/core/ims_ram.sv */
// ----------------------------------------------------------------------------
// ims_ram
// Generic RAM: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module ims_ram #(
    parameter int WIDTH = ims_pkg::DATA_W,
    parameter int DEPTH = ims_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

/* rtl/core/ims_front.sv */
// ----------------------------------------------------------------------------
// ims_front
// Accept input beats, count the set, mark kept and dropped elements.
// ----------------------------------------------------------------------------
module ims_front #(
    parameter int MAX_ELEMENTS = ims_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [ims_pkg::DATA_W-1:0]  i_value,
    input  logic                        i_last,
    input  logic                        i_full,
    output logic                        o_push,
    output ims_pkg::t_entry             o_entry
);

    localparam int IW = $clog2(MAX_ELEMENTS + 1);

    logic [IW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;
    logic          keep;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;
    assign keep    = (r_count != IW'(MAX_ELEMENTS));

    always_comb begin
        o_entry.value = i_value;
        o_entry.keep  = keep;
        o_entry.last  = i_last;
        o_entry.drop  = r_ovf || !keep;
    end

    always_comb begin
        n_count = r_count;
        n_ovf   = r_ovf;
        if (o_push) begin
            priority if (i_last) begin
                n_count = '0;
                n_ovf   = 1'b0;
            end else if (keep) begin
                n_count = r_count + IW'(1);
            end else begin
                n_ovf = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

endmodule

/* rtl/core/ims_queue.sv */
// ----------------------------------------------------------------------------
// ims_queue
// Short FIFO of classified elements between front and back.
// ----------------------------------------------------------------------------
module ims_queue #(
    parameter int DEPTH = ims_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ims_pkg::t_entry i_entry,
    output logic            o_full,
    input  logic            i_pop,
    output ims_pkg::t_entry o_entry,
    output logic            o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ims_pkg::t_entry r_mem [DEPTH];
    logic [PW-1:0]   r_wp, n_wp;
    logic [PW-1:0]   r_rp, n_rp;
    logic [CW-1:0]   r_cnt, n_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_entry = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
        end
        if (i_pop) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

/* rtl/core/ims_back.sv */
// ----------------------------------------------------------------------------
// ims_back
// Load the set into RAM, run bottom-up merge passes between two RAMs,
// then drain the sorted set through the output register.
// ----------------------------------------------------------------------------
module ims_back #(
    parameter int MAX_ELEMENTS = ims_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_empty,
    output logic                        o_pop,
    input  ims_pkg::t_entry             i_entry,
    output logic                        o_tvalid,
    input  logic                        i_tready,
    output logic [ims_pkg::DATA_W-1:0]  o_tdata,
    output logic                        o_tlast,
    output logic                        o_tuser
);

    localparam int IW = $clog2(MAX_ELEMENTS + 1);
    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int SW = IW + 2;
    localparam int DW = ims_pkg::DATA_W;

    typedef enum logic [4:0] {
        S_LOAD    = 5'b00001,
        S_PREP    = 5'b00010,
        S_MERGE   = 5'b00100,
        S_DRAIN_A = 5'b01000,
        S_DRAIN_B = 5'b10000
    } t_state;

    t_state          r_state, n_state;
    logic [IW-1:0]   r_n, n_n;
    logic [IW:0]     r_w, n_w;
    logic [IW-1:0]   r_mid, n_mid;
    logic [IW-1:0]   r_hi, n_hi;
    logic [IW-1:0]   r_i, n_i;
    logic [IW-1:0]   r_j, n_j;
    logic [IW-1:0]   r_k, n_k;
    logic            r_src, n_src;
    logic            r_drop, n_drop;
    logic            r_ov, n_ov;
    logic [DW-1:0]   r_out_data, n_out_data;
    logic            r_out_last, n_out_last;
    logic            r_out_drop, n_out_drop;

    logic            we0, we1;
    logic [AW-1:0]   waddr;
    logic [DW-1:0]   wdata;
    logic [AW-1:0]   raddr_a, raddr_b;
    logic [DW-1:0]   rd0_a, rd0_b, rd1_a, rd1_b;
    logic [DW-1:0]   rd_a, rd_b;
    logic            take_right;
    logic            slot_free;
    logic            draining;
    logic [IW-1:0]   seg_lo;
    logic [SW-1:0]   seg_mid_s, seg_hi_s;
    logic [IW-1:0]   seg_mid, seg_hi;
    logic [IW-1:0]   cnt_new;
    logic [IW:0]     w_dbl;

    ims_ram #(.WIDTH(DW), .DEPTH(MAX_ELEMENTS)) u_ram0 (
        .i_clk     (i_clk),
        .i_we      (we0),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rd0_a),
        .o_rdata_b (rd0_b)
    );

    ims_ram #(.WIDTH(DW), .DEPTH(MAX_ELEMENTS)) u_ram1 (
        .i_clk     (i_clk),
        .i_we      (we1),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rd1_a),
        .o_rdata_b (rd1_b)
    );

    assign rd_a       = r_src ? rd1_a : rd0_a;
    assign rd_b       = r_src ? rd1_b : rd0_b;
    assign take_right = (r_i == r_mid) ||
                        ((r_j != r_hi) && ($signed(rd_b) < $signed(rd_a)));
    assign slot_free  = !r_ov || i_tready;
    assign draining   = (r_state == S_DRAIN_A) || (r_state == S_DRAIN_B);
    assign raddr_a    = draining ? r_k[AW-1:0] : n_i[AW-1:0];
    assign raddr_b    = n_j[AW-1:0];

    // bounds of the next run pair
    assign seg_lo    = (r_state == S_PREP) ? '0 : r_hi;
    assign seg_mid_s = SW'(seg_lo) + SW'(r_w);
    assign seg_hi_s  = SW'(seg_lo) + (SW'(r_w) << 1);
    assign seg_mid   = (seg_mid_s > SW'(r_n)) ? r_n : seg_mid_s[IW-1:0];
    assign seg_hi    = (seg_hi_s > SW'(r_n)) ? r_n : seg_hi_s[IW-1:0];
    assign cnt_new   = r_n + IW'(i_entry.keep);
    assign w_dbl     = r_w << 1;

    always_comb begin
        n_state    = r_state;
        n_n        = r_n;
        n_w        = r_w;
        n_mid      = r_mid;
        n_hi       = r_hi;
        n_i        = r_i;
        n_j        = r_j;
        n_k        = r_k;
        n_src      = r_src;
        n_drop     = r_drop;
        n_ov       = r_ov && !i_tready;
        n_out_data = r_out_data;
        n_out_last = r_out_last;
        n_out_drop = r_out_drop;
        o_pop      = 1'b0;
        we0        = 1'b0;
        we1        = 1'b0;
        waddr      = r_k[AW-1:0];
        wdata      = take_right ? rd_b : rd_a;

        unique case (r_state)
            S_LOAD: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    if (i_entry.keep) begin
                        we0   = 1'b1;
                        waddr = r_n[AW-1:0];
                        wdata = i_entry.value;
                    end
                    n_n = cnt_new;
                    if (i_entry.last) begin
                        n_drop  = i_entry.drop;
                        n_w     = (IW + 1)'(1);
                        n_src   = 1'b0;
                        n_k     = '0;
                        n_state = (cnt_new > IW'(1)) ? S_PREP : S_DRAIN_A;
                    end
                end
            end
            S_PREP: begin
                n_i     = '0;
                n_j     = seg_mid;
                n_mid   = seg_mid;
                n_hi    = seg_hi;
                n_k     = '0;
                n_state = S_MERGE;
            end
            S_MERGE: begin
                we0 = r_src;
                we1 = !r_src;
                n_k = r_k + IW'(1);
                if (take_right) begin
                    n_j = r_j + IW'(1);
                end else begin
                    n_i = r_i + IW'(1);
                end
                if (r_k + IW'(1) == r_hi) begin
                    if (r_hi == r_n) begin
                        n_w   = w_dbl;
                        n_src = !r_src;
                        if (w_dbl >= (IW + 1)'(r_n)) begin
                            n_k     = '0;
                            n_state = S_DRAIN_A;
                        end else begin
                            n_state = S_PREP;
                        end
                    end else begin
                        n_i   = r_hi;
                        n_j   = seg_mid;
                        n_mid = seg_mid;
                        n_hi  = seg_hi;
                    end
                end
            end
            S_DRAIN_A: begin
                n_state = S_DRAIN_B;
            end
            S_DRAIN_B: begin
                if (slot_free) begin
                    n_ov       = 1'b1;
                    n_out_data = rd_a;
                    n_out_last = (r_k + IW'(1) == r_n);
                    n_out_drop = r_drop;
                    n_k        = r_k + IW'(1);
                    if (r_k + IW'(1) == r_n) begin
                        n_n     = '0;
                        n_state = S_LOAD;
                    end else begin
                        n_state = S_DRAIN_A;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_n     <= '0;
            r_ov    <= 1'b0;
            r_src   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            r_ov    <= n_ov;
            r_src   <= n_src;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w        <= n_w;
        r_mid      <= n_mid;
        r_hi       <= n_hi;
        r_i        <= n_i;
        r_j        <= n_j;
        r_k        <= n_k;
        r_drop     <= n_drop;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
        r_out_drop <= n_out_drop;
    end

    assign o_tvalid = r_ov;
    assign o_tdata  = r_out_data;
    assign o_tlast  = r_out_last;
    assign o_tuser  = r_out_drop;

endmodule

/* rtl/core/integer_merge_sorter.sv */
// ----------------------------------------------------------------------------
// integer_merge_sorter
// Collects a set of signed 32-bit values and streams it back sorted.
// ----------------------------------------------------------------------------
// Input stream: one signed value per beat on tdata, tlast on the final beat
// of the set. Output stream: values in ascending signed order, tlast on the
// last one, tuser high on every beat of a set that lost elements because it
// held more than MAX_ELEMENTS values (the extra ones are discarded).
// A four-entry queue sits between the accepting front end and the sorting
// back end, so input beats keep flowing while a sort or drain runs until
// that queue fills.
// The back end loads each popped element into RAM. After the final beat it
// runs ceil(log2(n)) merge passes between two RAMs, each pass bounded by
// the single write port; the sorted results then drain one by one, each
// through a registered RAM read and then the output register.
// Reset empties the queue, clears the set count and the output valid flag.
// A stalled receiver holds the output beat; the back end waits on it and
// the queue then absorbs input beats.
// ----------------------------------------------------------------------------
`include "integer_merge_sorter_assert.svh"

module integer_merge_sorter #(
    parameter int MAX_ELEMENTS = ims_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [ims_pkg::DATA_W-1:0]  i_s_tdata,  // [31:0] value
    input  logic                        i_s_tlast,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [ims_pkg::DATA_W-1:0]  o_m_tdata,  // [31:0] sorted_value
    output logic                        o_m_tlast,
    output logic                        o_m_tuser   // [0] dropped
);

    ims_pkg::t_entry push_entry;
    ims_pkg::t_entry pop_entry;
    logic            q_push;
    logic            q_pop;
    logic            q_full;
    logic            q_empty;

    ims_front #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_value (i_s_tdata),
        .i_last  (i_s_tlast),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_entry (push_entry)
    );

    ims_queue #(.DEPTH(ims_pkg::QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (push_entry),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_entry (pop_entry),
        .o_empty (q_empty)
    );

    ims_back #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (q_empty),
        .o_pop    (q_pop),
        .i_entry  (pop_entry),
        .o_tvalid (o_m_tvalid),
        .i_tready (i_m_tready),
        .o_tdata  (o_m_tdata),
        .o_tlast  (o_m_tlast),
        .o_tuser  (o_m_tuser)
    );

    `IMS_ASSERT_NOW(a_pop_nonempty, i_clk, i_rst_n, q_pop, !q_empty)
    `IMS_ASSERT_NEXT(a_push_fills, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !q_empty)
    `IMS_ASSERT_NOW(a_full_stalls, i_clk, i_rst_n, q_full, !q_push)

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Streams signed sets into integer_merge_sorter and checks the sorted output.
// ----------------------------------------------------------------------------
// Each set is loaded beat by beat, with tlast on its final value. A local
// model keeps the set, orders it once the final beat is taken, and queues
// the expected output beats. Output beats are checked in order for value,
// tlast and the overflow flag on tuser. Directed sets come first, then
// random sets under changing idle patterns, including a full set, an
// overflowing set and a long receiver stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

    localparam int DATA_W      = ims_pkg::DATA_W;
    localparam int STORE_DEPTH = ims_pkg::MAX_ELEMENTS_DEF;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 100;

    localparam logic [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] MOST_POS = {1'b0, {(DATA_W-1){1'b1}}};

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              is_final;
    } t_element_beat;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              end_of_set;
        logic              dropped;
    } t_sorted_beat;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_s_tvalid = 1'b0;
    logic              o_s_tready;
    logic [DATA_W-1:0] i_s_tdata = '0;  // [31:0] value
    logic              i_s_tlast = 1'b0;
    logic              o_m_tvalid;
    logic              i_m_tready = 1'b0;
    logic [DATA_W-1:0] o_m_tdata;       // [31:0] sorted_value
    logic              o_m_tlast;
    logic              o_m_tuser;       // [0] dropped

    t_element_beat element_backlog[$];
    t_sorted_beat  sorted_due[$];

    logic signed [DATA_W-1:0] held_elements[STORE_DEPTH];
    int                       held_count = 0;
    bit                       held_overflow = 1'b0;

    int   error_count = 0;
    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    logic hold_go = 1'b0;
    logic hold_go_seen = 1'b0;
    int   hold_left = 0;
    logic s_took = 1'b0;
    int   quiet_cycles = 0;

    integer_merge_sorter dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    always #5 i_clk = ~i_clk;

    task automatic flag_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
        $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
        error_count++;
    endtask

    // keep the element, and on the final beat release the set in ascending order
    function automatic void absorb_element(logic [DATA_W-1:0] value, logic is_final);
        logic signed [DATA_W-1:0] ordered[STORE_DEPTH];
        logic signed [DATA_W-1:0] key;
        t_sorted_beat             beat;
        int                       j;
        if (held_count < STORE_DEPTH) begin
            held_elements[held_count] = value;
            held_count++;
        end else begin
            held_overflow = 1'b1;
        end
        if (is_final) begin
            for (int i = 0; i < held_count; i++) begin
                ordered[i] = held_elements[i];
            end
            for (int i = 1; i < held_count; i++) begin
                key = ordered[i];
                j = i - 1;
                while (j >= 0 && ordered[j] > key) begin
                    ordered[j+1] = ordered[j];
                    j--;
                end
                ordered[j+1] = key;
            end
            for (int i = 0; i < held_count; i++) begin
                beat.value      = ordered[i];
                beat.end_of_set = (i == held_count - 1);
                beat.dropped    = held_overflow;
                sorted_due = {sorted_due, beat};
            end
            held_count    = 0;
            held_overflow = 1'b0;
        end
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        unique case ($urandom_range(9))
            0: return MOST_NEG;
            1: return MOST_POS;
            2: return '0;
            3: return '1;
            4, 5: return DATA_W'($signed($urandom_range(15)) - 8);
            default: return $urandom();
        endcase
    endfunction

    task automatic push_element(logic [DATA_W-1:0] value, logic is_final);
        t_element_beat beat;
        beat.value    = value;
        beat.is_final = is_final;
        element_backlog = {element_backlog, beat};
    endtask

    task automatic queue_random_set(int n);
        for (int i = 0; i < n; i++) begin
            push_element(pick_value(), i == n - 1);
        end
    endtask

    task automatic queue_random_sets(int budget);
        int n;
        while (budget > 0) begin
            n = $urandom_range(1, 12);
            if (n > budget) begin
                n = budget;
            end
            queue_random_set(n);
            budget -= n;
        end
    endtask

    task automatic wait_drained();
        while (element_backlog.size() != 0 || i_s_tvalid || sorted_due.size() != 0) begin
            @(posedge i_clk);
        end
        @(posedge i_clk);
    endtask

    // sender
    always @(negedge i_clk) begin : drive_input
        t_element_beat nxt;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || s_took) begin
            if (element_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                nxt = element_backlog.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= nxt.value;
                i_s_tlast  <= nxt.is_final;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (hold_go != hold_go_seen) begin
            hold_go_seen <= hold_go;
            hold_left    <= HOLD_CYCLES;
            i_m_tready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left  <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // predict, check, and guard against a hang
    always @(posedge i_clk) begin : watch_ports
        t_sorted_beat want;
        if (!i_rst_n) begin
            s_took       <= 1'b0;
            quiet_cycles = 0;
        end else begin
            s_took <= i_s_tvalid && o_s_tready;
            if (i_s_tvalid && o_s_tready) begin
                absorb_element(i_s_tdata, i_s_tlast);
            end
            if (o_m_tvalid && i_m_tready) begin
                if (sorted_due.size() == 0) begin
                    flag_mismatch("unexpected beat", o_m_tdata, '0);
                end else begin
                    want = sorted_due.pop_front();
                    if (o_m_tdata !== want.value) begin
                        flag_mismatch("sorted_value", o_m_tdata, want.value);
                    end
                    if (o_m_tlast !== want.end_of_set) begin
                        flag_mismatch("end_of_set", DATA_W'(o_m_tlast), DATA_W'(want.end_of_set));
                    end
                    if (o_m_tuser !== want.dropped) begin
                        flag_mismatch("dropped", DATA_W'(o_m_tuser), DATA_W'(want.dropped));
                    end
                end
            end
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("testbench: errors");
                $finish;
            end
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(posedge i_clk);

        tx_idle_pct = 13;
        rx_idle_pct = 69;
        push_element(MOST_POS, 1'b1);
        push_element(MOST_NEG, 1'b1);
        push_element(MOST_POS, 1'b0);
        push_element(MOST_NEG, 1'b0);
        push_element('0, 1'b0);
        push_element('1, 1'b0);
        push_element(DATA_W'(1), 1'b1);
        push_element(DATA_W'(7), 1'b0);
        push_element(-DATA_W'(3), 1'b0);
        push_element(DATA_W'(7), 1'b0);
        push_element(-DATA_W'(3), 1'b0);
        push_element(DATA_W'(7), 1'b1);
        for (int i = 3; i >= -2; i--) begin
            push_element(DATA_W'(i), i == -2);
        end
        push_element(32'h5555_5555, 1'b0);
        push_element(32'hAAAA_AAAA, 1'b1);
        wait_drained();

        // exactly full, then mostly small sets
        queue_random_set(STORE_DEPTH);
        queue_random_sets(80);
        wait_drained();

        tx_idle_pct = 69;
        rx_idle_pct = 13;
        // overflow, final beat dropped as well
        queue_random_set(STORE_DEPTH + 2);
        queue_random_sets(80);
        wait_drained();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_go = ~hold_go;
        queue_random_sets(50);
        wait_drained();

        queue_random_sets(80);
        wait_drained();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/ims_pkg.sv
rtl/core/ims_ram.sv
rtl/core/ims_front.sv
rtl/core/ims_queue.sv
rtl/core/ims_back.sv
rtl/core/integer_merge_sorter.sv
verif/testbench.sv
